[sv/ppaf_pkg.sv]
// Shared types, constants and helpers for the primer pair amplicon finder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ppaf_pkg;

  // Fixed field widths
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned PRIMER_W = 64;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned MIN_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_PRIMER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_PRIMER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMER_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMP    = 2'd3;

  // Reset values of the registers
  localparam logic [LEN_W-1:0] PRIMER_LEN_RST = 6'd20;
  localparam logic [MIN_W-1:0] MIN_AMP_RST    = 13'd50;

  // Byte values of the valid bases
  localparam logic [SYM_W-1:0] BASE_FIRST = 8'd65;
  localparam logic [SYM_W-1:0] BASE_LAST  = 8'd68;

  // Window match flags, one per primer
  typedef struct packed {
    logic fwd;
    logic rev;
  } hit_t;

  // Byte to window code: bit 2 marks a valid base, bits 1:0 the base
  function automatic logic [CODE_W-1:0] encode_symbol(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] offs;
    offs = sym - BASE_FIRST;
    if (sym >= BASE_FIRST && sym <= BASE_LAST) begin
      return {1'b1, offs[1:0]};
    end
    return '0;
  endfunction

  // Primer length clamped to 1..max_len
  function automatic logic [LEN_W-1:0] active_length(input logic [LEN_W-1:0] raw,
                                                      input logic [LEN_W-1:0] max_len);
    if (raw == '0) begin
      return 6'd1;
    end
    if (raw > max_len) begin
      return max_len;
    end
    return raw;
  endfunction

endpackage

`default_nettype wire

[sv/ppaf_if.sv]
// Valid/ready channel interfaces: sequence bytes in, amplicon report out.
// Depends on ppaf_pkg for field widths.
`default_nettype none

interface ppaf_in_if;
  logic                           valid;
  logic                           ready;
  logic [ppaf_pkg::SYM_W-1:0]     symbol;
  logic                           last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// POS_W must equal $clog2(SEQ_MAX) of the finder it connects to
interface ppaf_out_if #(
  parameter int unsigned POS_W = 12
);
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] start_pos;
  logic [POS_W:0]   end_pos;

  modport source (output valid, output found, output start_pos, output end_pos, input ready);
  modport sink   (input valid, input found, input start_pos, input end_pos, output ready);
endinterface

`default_nettype wire

[sv/primer_pair_amplicon_finder.sv]
// Primer pair amplicon finder, top level: configuration registers, stream
// state and the cell row. Depends on ppaf_pkg, ppaf_if, ppaf_chain, ppaf_report.
//
// Takes one sequence byte per cycle with no gaps, for as long as the result
// channel keeps up. The row of PRIMER_MAX cells compares the whole window
// against both primers in the cycle a byte is accepted, which sets the
// single-cycle rate. One result follows each byte marked last, through the
// capture and output registers; a result that waits does not stop the stream
// until a second last-marked byte arrives behind it. The stream state clears
// at once at the end of each sequence, so there is no clearing pass. The
// output interface must be built with POS_W = $clog2(SEQ_MAX).
`default_nettype none

module primer_pair_amplicon_finder #(
  parameter int unsigned PRIMER_MAX = 32,
  parameter int unsigned SEQ_MAX    = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppaf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ppaf_pkg::PRIMER_W-1:0]  cfg_data_i,
  ppaf_in_if.sink                             in_i,
  ppaf_out_if.source                          out_o
);

  localparam int unsigned SW = $clog2(SEQ_MAX);
  localparam int unsigned EW = SW + 1;
  localparam int unsigned PW = (EW > ppaf_pkg::LEN_W) ? EW : ppaf_pkg::LEN_W;

  // Configuration registers
  logic [ppaf_pkg::PRIMER_W-1:0] fwd_primer_q, rev_primer_q;
  logic [ppaf_pkg::LEN_W-1:0]    primer_len_q;
  logic [ppaf_pkg::MIN_W-1:0]    min_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_primer_q <= '0;
      rev_primer_q <= '0;
      primer_len_q <= ppaf_pkg::PRIMER_LEN_RST;
      min_amp_q    <= ppaf_pkg::MIN_AMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppaf_pkg::CFG_FWD_PRIMER: fwd_primer_q <= cfg_data_i;
        ppaf_pkg::CFG_REV_PRIMER: rev_primer_q <= cfg_data_i;
        ppaf_pkg::CFG_PRIMER_LEN: primer_len_q <= cfg_data_i[ppaf_pkg::LEN_W-1:0];
        ppaf_pkg::CFG_MIN_AMP:    min_amp_q    <= cfg_data_i[ppaf_pkg::MIN_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Input handshake
  logic ready, accept, shift, clear;
  logic [ppaf_pkg::LEN_W-1:0] len;
  ppaf_pkg::hit_t hit;

  logic [EW-1:0] pos_q, pos_d, pos_next;
  logic          fseen_q, fseen_d, rseen_q, rseen_d;
  logic [SW-1:0] fstart_q, fstart_d;
  logic [EW-1:0] rend_q, rend_d;
  logic          fseen_n, rseen_n;
  logic [SW-1:0] fstart_n;
  logic [EW-1:0] rend_n;

  assign accept    = in_i.valid && ready;
  assign in_i.ready = ready;
  assign shift     = accept && (pos_q < EW'(SEQ_MAX));
  assign clear     = accept && in_i.last;
  assign len       = ppaf_pkg::active_length(primer_len_q, ppaf_pkg::LEN_W'(PRIMER_MAX));
  assign pos_next  = pos_q + EW'(1);

  ppaf_chain #(
    .PRIMER_MAX (PRIMER_MAX)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (shift),
    .clear_i      (clear),
    .code_i       (ppaf_pkg::encode_symbol(in_i.symbol)),
    .fwd_primer_i (fwd_primer_q),
    .rev_primer_i (rev_primer_q),
    .len_i        (len),
    .hit_o        (hit)
  );

  // Match bookkeeping; an all-valid window implies len symbols since the clear
  always_comb begin
    fseen_n  = fseen_q;
    fstart_n = fstart_q;
    rseen_n  = rseen_q;
    rend_n   = rend_q;
    if (shift) begin
      if (!fseen_q && hit.fwd) begin
        fseen_n  = 1'b1;
        fstart_n = SW'(PW'(pos_next) - PW'(len));
      end
      if (hit.rev) begin
        rseen_n = 1'b1;
        rend_n  = pos_next;
      end
    end
  end

  // End of sequence returns the stream state to reset
  always_comb begin
    pos_d    = shift ? pos_next : pos_q;
    fseen_d  = fseen_n;
    fstart_d = fstart_n;
    rseen_d  = rseen_n;
    rend_d   = rend_n;
    if (clear) begin
      pos_d    = '0;
      fseen_d  = 1'b0;
      fstart_d = '0;
      rseen_d  = 1'b0;
      rend_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fseen_q  <= 1'b0;
      fstart_q <= '0;
      rseen_q  <= 1'b0;
      rend_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      fseen_q  <= fseen_d;
      fstart_q <= fstart_d;
      rseen_q  <= rseen_d;
      rend_q   <= rend_d;
    end
  end

  ppaf_report #(
    .SEQ_MAX (SEQ_MAX)
  ) u_report (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capture_i   (clear),
    .fwd_seen_i  (fseen_n),
    .fwd_start_i (fstart_n),
    .rev_seen_i  (rseen_n),
    .rev_end_i   (rend_n),
    .min_amp_i   (min_amp_q),
    .ready_o     (ready),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // Position saturates at the sequence limit
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= EW'(SEQ_MAX))
    else $error("position passed the sequence limit");

  // A last beat leaves the stream state cleared
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last) |=> (pos_q == '0 && !fseen_q && !rseen_q))
    else $error("stream state not cleared after last beat");

  // A found report always has the forward start before the reverse end
  a_found_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (EW'(out_o.start_pos) < out_o.end_pos))
    else $error("found report with start not before end");

  // A miss reports zero positions
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.start_pos == '0 && out_o.end_pos == '0))
    else $error("miss report carries positions");
`endif

endmodule

`default_nettype wire

[sv/ppaf_cell.sv]
// One window cell: holds a symbol code, passes it on, and checks the code
// it is about to take against both primer symbols. Depends on ppaf_pkg.
`default_nettype none

module ppaf_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        shift_i,
  input  wire logic                        clear_i,
  input  wire logic                        en_i,
  input  wire logic [1:0]                  want_fwd_i,
  input  wire logic [1:0]                  want_rev_i,
  input  wire logic [ppaf_pkg::CODE_W-1:0] code_i,
  output      logic [ppaf_pkg::CODE_W-1:0] code_o,
  output      ppaf_pkg::hit_t              hit_o
);

  logic [ppaf_pkg::CODE_W-1:0] code_q, code_d;

  // Shift register stage, cleared at end of sequence
  always_comb begin
    code_d = code_q;
    if (clear_i) begin
      code_d = '0;
    end else if (shift_i) begin
      code_d = code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

  // Cells past the primer length always agree
  assign hit_o.fwd = !en_i || (code_i[2] && (code_i[1:0] == want_fwd_i));
  assign hit_o.rev = !en_i || (code_i[2] && (code_i[1:0] == want_rev_i));

endmodule

`default_nettype wire

[sv/ppaf_chain.sv]
// Row of window cells with primer alignment and match reduction.
// Depends on ppaf_pkg and ppaf_cell.
`default_nettype none

module ppaf_chain #(
  parameter int unsigned PRIMER_MAX = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          shift_i,
  input  wire logic                          clear_i,
  input  wire logic [ppaf_pkg::CODE_W-1:0]   code_i,
  input  wire logic [ppaf_pkg::PRIMER_W-1:0] fwd_primer_i,
  input  wire logic [ppaf_pkg::PRIMER_W-1:0] rev_primer_i,
  input  wire logic [ppaf_pkg::LEN_W-1:0]    len_i,
  output      ppaf_pkg::hit_t                hit_o
);

  localparam int unsigned VEC_W = 2 * PRIMER_MAX;

  logic [VEC_W-1:0]                  fwd_rev, rev_rev;
  logic [VEC_W-1:0]                  fwd_align, rev_align;
  logic [ppaf_pkg::LEN_W-1:0]        skip;
  logic [ppaf_pkg::LEN_W:0]          skip_bits;
  logic [ppaf_pkg::CODE_W-1:0]       link [PRIMER_MAX+1];
  logic [PRIMER_MAX-1:0]             fwd_hits, rev_hits;
  ppaf_pkg::hit_t                    cell_hit [PRIMER_MAX];

  // Reverse symbol order so cell k sees primer symbol len-1-k after the shift
  always_comb begin
    for (int j = 0; j < PRIMER_MAX; j++) begin
      fwd_rev[2*j +: 2] = fwd_primer_i[2*(PRIMER_MAX-1-j) +: 2];
      rev_rev[2*j +: 2] = rev_primer_i[2*(PRIMER_MAX-1-j) +: 2];
    end
  end

  assign skip      = ppaf_pkg::LEN_W'(PRIMER_MAX) - len_i;
  assign skip_bits = {skip, 1'b0};
  assign fwd_align = fwd_rev >> skip_bits;
  assign rev_align = rev_rev >> skip_bits;

  assign link[0] = code_i;

  for (genvar k = 0; k < PRIMER_MAX; k++) begin : g_cell
    logic en;
    assign en = ppaf_pkg::LEN_W'(k) < len_i;

    ppaf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift_i),
      .clear_i    (clear_i),
      .en_i       (en),
      .want_fwd_i (fwd_align[2*k +: 2]),
      .want_rev_i (rev_align[2*k +: 2]),
      .code_i     (link[k]),
      .code_o     (link[k+1]),
      .hit_o      (cell_hit[k])
    );

    assign fwd_hits[k] = cell_hit[k].fwd;
    assign rev_hits[k] = cell_hit[k].rev;
  end

  // Every active cell must agree; an invalid code in range blocks the hit
  assign hit_o.fwd = &fwd_hits;
  assign hit_o.rev = &rev_hits;

endmodule

`default_nettype wire

[sv/ppaf_report.sv]
// Report stages: holds the captured end-of-sequence state, evaluates the
// amplicon test and drives the result channel. Depends on ppaf_pkg, ppaf_if.
`default_nettype none

module ppaf_report #(
  parameter int unsigned SEQ_MAX = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       capture_i,
  input  wire logic                       fwd_seen_i,
  input  wire logic [$clog2(SEQ_MAX)-1:0] fwd_start_i,
  input  wire logic                       rev_seen_i,
  input  wire logic [$clog2(SEQ_MAX):0]   rev_end_i,
  input  wire logic [ppaf_pkg::MIN_W-1:0] min_amp_i,
  output      logic                       ready_o,
  ppaf_out_if.source                      out_o
);

  localparam int unsigned SW = $clog2(SEQ_MAX);
  localparam int unsigned EW = SW + 1;
  localparam int unsigned CW = (EW > ppaf_pkg::MIN_W) ? EW : ppaf_pkg::MIN_W;

  logic          ev_valid_q, ev_valid_d;
  logic          ev_fseen_q, ev_rseen_q;
  logic [SW-1:0] ev_start_q;
  logic [EW-1:0] ev_end_q;

  logic          out_valid_q, out_valid_d;
  logic          found_q, found_d;
  logic [SW-1:0] start_q, start_d;
  logic [EW-1:0] end_q, end_d;

  logic          out_free, ev_move;
  logic [EW-1:0] start_ext, span;
  logic          ordered, long_enough;

  // Handshake between the stages
  assign out_free = !out_valid_q || out_o.ready;
  assign ev_move  = ev_valid_q && out_free;
  assign ready_o  = !ev_valid_q || out_free;

  always_comb begin
    ev_valid_d = ev_valid_q;
    if (capture_i) begin
      ev_valid_d = 1'b1;
    end else if (ev_move) begin
      ev_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ev_move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Amplicon test on the captured state
  assign start_ext   = EW'(ev_start_q);
  assign span        = ev_end_q - start_ext;
  assign ordered     = start_ext < ev_end_q;
  assign long_enough = CW'(span) >= CW'(min_amp_i);

  always_comb begin
    found_d = ev_fseen_q && ev_rseen_q && ordered && long_enough;
    start_d = found_d ? ev_start_q : '0;
    end_d   = found_d ? ev_end_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      ev_fseen_q <= fwd_seen_i;
      ev_rseen_q <= rev_seen_i;
      ev_start_q <= fwd_start_i;
      ev_end_q   <= rev_end_i;
    end
    if (ev_move) begin
      found_q <= found_d;
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = found_q;
  assign out_o.start_pos = start_q;
  assign out_o.end_pos   = end_q;

endmodule

`default_nettype wire
